// ----- rtl/sllf_pkg.sv -----
// Shared types and constants for the serial log line filter.
// No dependencies; imported by every other file of the block.
package sllf_pkg;

	localparam int unsigned MAX_LEN_DEF = 256;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned LEN_W       = 8;

	localparam logic [BYTE_W-1:0] VENDOR_MARK  = 8'h01;
	localparam logic [BYTE_W-1:0] VENDOR_TAG_A = 8'h60;
	localparam logic [BYTE_W-1:0] VENDOR_TAG_B = 8'h62;
	localparam logic [BYTE_W-1:0] ESC_START    = 8'h1b;
	localparam logic [BYTE_W-1:0] ESC_END      = 8'h6d;
	localparam logic [BYTE_W-1:0] CHAR_CR      = 8'h0d;
	localparam logic [BYTE_W-1:0] CHAR_LF      = 8'h0a;

	typedef struct packed {
		logic              vendor_pend;
		logic              esc_act;
		logic              cr_seen;
		logic [LEN_W-1:0]  line_cnt;
	} filt_state_t;

	typedef struct packed {
		logic              emit;
		logic              has_byte;
		logic [BYTE_W-1:0] out_byte;
		logic              end_of_line;
		logic [LEN_W-1:0]  line_length;
	} filt_res_t;

endpackage

// ----- rtl/sllf_in_if.sv -----
// Input channel of the serial log line filter: one received byte per transfer.
// Depends on sllf_pkg.
interface sllf_in_if import sllf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/sllf_out_if.sv -----
// Result channel of the serial log line filter: kept byte and end-of-line mark.
// Depends on sllf_pkg.
interface sllf_out_if import sllf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              has_byte;
	logic [BYTE_W-1:0] out_byte;
	logic              end_of_line;
	logic [LEN_W-1:0]  line_length;

	modport source (output valid, output has_byte, output out_byte,
		output end_of_line, output line_length, input ready);
	modport sink   (input valid, input has_byte, input out_byte,
		input end_of_line, input line_length, output ready);
endinterface

// ----- rtl/sllf_decide.sv -----
// Per-byte drop decision, flag update and line length logic (combinational).
// Depends on sllf_pkg.
module sllf_decide import sllf_pkg::*; #(
	parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
	input  logic [BYTE_W-1:0] rx_byte,
	input  filt_state_t       cur,
	output filt_state_t       nxt,
	output filt_res_t         res
);

	localparam logic [LEN_W-1:0] LIMIT = LEN_W'(MAX_LEN - 1);

	logic             dropped;
	logic [LEN_W-1:0] cnt_inc;
	logic             flush;

	always_comb begin
		nxt.vendor_pend = cur.vendor_pend;
		nxt.esc_act     = cur.esc_act;
		nxt.cr_seen     = cur.cr_seen;
		dropped         = 1'b1;
		// priority: vendor marker, escape sequence, CR/LF
		if (rx_byte == VENDOR_MARK) begin
			nxt.vendor_pend = 1'b1;
		end else if (cur.vendor_pend &&
				(rx_byte == VENDOR_TAG_A || rx_byte == VENDOR_TAG_B)) begin
			nxt.vendor_pend = 1'b0;
		end else if (rx_byte == ESC_START) begin
			nxt.esc_act = 1'b1;
		end else if (cur.esc_act) begin
			if (rx_byte == ESC_END) begin
				nxt.esc_act = 1'b0;
			end
		end else if (rx_byte == CHAR_CR) begin
			nxt.cr_seen = 1'b1;
		end else if (cur.cr_seen && rx_byte == CHAR_LF) begin
			nxt.cr_seen = 1'b0;
		end else begin
			dropped = 1'b0;
		end

		cnt_inc = dropped ? cur.line_cnt : cur.line_cnt + LEN_W'(1);
		// a dropped LF ends the line, even inside an escape sequence
		flush   = (dropped && rx_byte == CHAR_LF) || (cnt_inc == LIMIT);
		nxt.line_cnt = flush ? '0 : cnt_inc;

		res.emit        = !dropped || flush;
		res.has_byte    = !dropped;
		res.out_byte    = dropped ? '0 : rx_byte;
		res.end_of_line = flush;
		res.line_length = flush ? cnt_inc : '0;
	end

endmodule

// ----- rtl/serial_log_line_filter_unit.sv -----
// Serial log line filter, top level: input register, decision logic, result register.
// Depends on sllf_pkg, sllf_in_if, sllf_out_if and sllf_decide.
//
// Usage:
//   rx  : one received serial byte per transfer (valid/ready).
//   res : zero or one result per byte: a kept byte (has_byte), an
//         end-of-line mark with the line length (end_of_line,
//         line_length), or both in the same transfer. Dropped bytes
//         that do not end a line give no transfer.
//   Path: a byte taken on rx reaches res through the input register,
//   then the result register.
//   Throughput: one byte per cycle, sustained, while res is drained.
//   Stall: when res holds a result that is not taken, the decision
//   stage holds; rx takes at most one more byte, into the input
//   register if it is empty, and then deasserts ready until res moves.
//   Reset (arst_n low): marker flags and the line count clear, both
//   registers empty; no clearing pass, ready right after reset.
module serial_log_line_filter_unit import sllf_pkg::*; #(
	parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sllf_in_if.sink    rx,
	sllf_out_if.source res
);

	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	filt_state_t       st_q;
	filt_state_t       st_nxt;
	filt_res_t         dec_res;
	logic              res_vld_q;
	filt_res_t         res_q;
	logic              advance;

	// decision stage moves when the result register is free or being drained
	assign advance  = vld_s1 && (!res_vld_q || res.ready);
	assign rx.ready = !vld_s1 || advance;

	sllf_decide #(
		.MAX_LEN(MAX_LEN)
	) u_decide (
		.rx_byte (byte_s1),
		.cur     (st_q),
		.nxt     (st_nxt),
		.res     (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rx.ready) begin
			vld_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (advance) begin
			res_vld_q <= dec_res.emit;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec_res.emit) begin
			res_q <= dec_res;
		end
	end

	assign res.valid       = res_vld_q;
	assign res.has_byte    = res_q.has_byte;
	assign res.out_byte    = res_q.out_byte;
	assign res.end_of_line = res_q.end_of_line;
	assign res.line_length = res_q.line_length;

endmodule
